// ----- hdl/http_message_head_parser_macros.svh -----
// assertion macros for the http message head parser checker
// no dependencies
`ifndef HTTP_MESSAGE_HEAD_PARSER_MACROS_SVH
`define HTTP_MESSAGE_HEAD_PARSER_MACROS_SVH
// implication checked on every clock edge outside reset
`define HMP_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define HMP_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hdl/hmp_pkg.sv -----
// shared types and constants for the http message head parser
// no dependencies
`default_nettype none
package hmp_pkg;
  localparam int MAX_LINE = 1024;
  localparam int LW = $clog2(MAX_LINE + 1);

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_SP = 8'd32;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_COLON = 8'd58;
  localparam logic [7:0] BYTE_DOT = 8'd46;
  localparam logic [7:0] BYTE_ZERO = 8'd48;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_HEADERS = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [3:0] STEP_METHOD = 4'd0;
  localparam logic [3:0] STEP_URI = 4'd1;
  localparam logic [3:0] STEP_PROTO = 4'd2;
  localparam logic [3:0] STEP_PROTO_END = 4'd6;
  localparam logic [3:0] STEP_VMAJ = 4'd7;
  localparam logic [3:0] STEP_VDOT = 4'd8;
  localparam logic [3:0] STEP_VMIN = 4'd9;
  localparam logic [3:0] STEP_DONE = 4'd10;
  localparam logic [3:0] STEP_SP1 = 4'd11;
  localparam logic [3:0] STEP_ST0 = 4'd12;
  localparam logic [3:0] STEP_ST2 = 4'd14;
  localparam logic [3:0] STEP_SP2 = 4'd15;

  localparam logic [3:0] ERR_OK = 4'd0;
  localparam logic [3:0] ERR_LONG = 4'd1;
  localparam logic [3:0] ERR_NO_METHOD = 4'd2;
  localparam logic [3:0] ERR_BAD_METHOD = 4'd3;
  localparam logic [3:0] ERR_NO_URI = 4'd4;
  localparam logic [3:0] ERR_PROTO = 4'd5;
  localparam logic [3:0] ERR_VERSION = 4'd6;
  localparam logic [3:0] ERR_STATUS = 4'd7;
  localparam logic [3:0] ERR_CONT = 4'd8;
  localparam logic [3:0] ERR_NO_COLON = 4'd9;
  localparam logic [3:0] ERR_NO_SPACE = 4'd10;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_HEADER = 3'd3;
  localparam logic [2:0] KIND_END = 3'd4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [9:0] line_offset;
    logic in_body;
    logic line_done;
    logic [2:0] line_kind;
    logic [3:0] error_code;
    logic [1:0] method_code;
    logic [1:0] version_code;
    logic [9:0] status_number;
    logic [9:0] name_length;
    logic [9:0] value_start;
    logic [9:0] value_length;
  } result_t;

  function automatic logic [7:0] method_char(input logic [1:0] m, input logic [2:0] p);
    logic [7:0] c;
    c = 8'd0;
    unique case (m)
      2'd0: c = (p == 3'd0) ? "G" : (p == 3'd1) ? "E" : (p == 3'd2) ? "T" : 8'd0;
      2'd1: c = (p == 3'd0) ? "P" : (p == 3'd1) ? "O" : (p == 3'd2) ? "S" :
                (p == 3'd3) ? "T" : 8'd0;
      2'd2: c = (p == 3'd0) ? "P" : (p == 3'd1) ? "U" : (p == 3'd2) ? "T" : 8'd0;
      default: c = (p == 3'd0 || p == 3'd2) ? "D" : (p == 3'd1 || p == 3'd3) ? "E" :
                   (p == 3'd4) ? "T" : (p == 3'd5) ? "E" : 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] method_len(input logic [1:0] m);
    logic [2:0] l;
    unique case (m)
      2'd0: l = 3'd3;
      2'd1: l = 3'd4;
      2'd2: l = 3'd3;
      default: l = 3'd6;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] proto_char(input logic [3:0] s);
    logic [7:0] c;
    unique case (s)
      4'd2: c = "H";
      4'd3: c = "T";
      4'd4: c = "T";
      4'd5: c = "P";
      default: c = "/";
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/hmp_front.sv -----
// front part: accepts bytes and runs the line parse registers
// uses hmp_pkg
`default_nettype none
module hmp_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_mode,
  input  wire logic [10:0] cfg_max,
  input  wire logic take,
  input  wire logic [7:0] data_byte,
  output hmp_pkg::result_t res
);
  import hmp_pkg::*;

  logic [1:0] phase, phase_next;
  logic [LW-1:0] line_length, line_length_next;
  logic [3:0] step, step_next;
  logic [3:0] cand, cand_next;
  logic colon_seen, colon_seen_next;
  logic [LW-1:0] colon_pos, colon_pos_next;
  logic [LW-1:0] value_begin, value_begin_next;
  logic [LW-1:0] uri_begin, uri_begin_next;
  logic [7:0] vdig, vdig_next;
  logic [9:0] sdig, sdig_next;
  logic last_cr, last_cr_next;
  logic [3:0] sticky, sticky_next;

  logic [LW-1:0] limit, pos, term, vlen;
  logic [7:0] vsum;
  logic [3:0] err, hit;
  logic [3:0] d;
  logic is_dig, is_blank, nl;
  logic [1:0] mc;
  logic [13:0] st_mul;

  always_comb begin
    limit = ({{(LW > 11 ? LW-11 : 0){1'b0}}, cfg_max} < LW'(MAX_LINE)) ?
            LW'(cfg_max) : LW'(MAX_LINE);
    pos = line_length;
    d = data_byte[3:0];
    is_dig = data_byte >= 8'd48 && data_byte <= 8'd57;
    is_blank = data_byte == BYTE_SP || data_byte == BYTE_TAB;
    term = last_cr ? LW'(2) : LW'(1);
    vsum = vdig + 8'(d);
    st_mul = 14'(sdig) * 14'd10 + 14'(d);
    phase_next = phase; line_length_next = line_length; step_next = step;
    cand_next = cand; colon_seen_next = colon_seen; colon_pos_next = colon_pos;
    value_begin_next = value_begin; uri_begin_next = uri_begin;
    vdig_next = vdig; sdig_next = sdig; last_cr_next = last_cr; sticky_next = sticky;
    err = ERR_OK; nl = 1'b0; hit = 4'd0; mc = 2'd0; vlen = '0;
    res = '0;
    res.out_byte = data_byte;
    if (sticky != ERR_OK) begin
      res.error_code = sticky;
    end else if (phase == PH_BODY) begin
      res.in_body = 1'b1;
    end else if (line_length >= limit) begin
      sticky_next = ERR_LONG;
      res.line_offset = 10'(line_length);
      res.error_code = ERR_LONG;
    end else begin
      line_length_next = line_length + LW'(1);
      res.line_offset = 10'(pos);
      if (phase == PH_FIRST && pos == '0 && step == STEP_METHOD && cfg_mode)
        step_next = STEP_PROTO;
      if (data_byte != BYTE_LF) begin
        if (phase == PH_FIRST) begin
          if (step_next == STEP_METHOD) begin
            if (data_byte == BYTE_SP) begin
              for (int i = 0; i < 4; i++)
                if (cand[i] && LW'(method_len(2'(i))) == pos) hit = 4'(1) << i;
              if (hit == 4'd0) err = ERR_BAD_METHOD;
              else begin
                cand_next = hit; uri_begin_next = pos + LW'(1); step_next = STEP_URI;
              end
            end else begin
              for (int i = 0; i < 4; i++)
                if (!(pos < LW'(method_len(2'(i))) &&
                      method_char(2'(i), pos[2:0]) == data_byte))
                  cand_next[i] = 1'b0;
            end
          end else if (step_next == STEP_URI) begin
            if (data_byte == BYTE_SP) begin
              value_begin_next = pos; step_next = STEP_PROTO;
            end
          end else if (step_next >= STEP_PROTO && step_next <= STEP_PROTO_END) begin
            if (data_byte != proto_char(step_next)) err = ERR_PROTO;
            else step_next = step_next + 4'd1;
          end else if (step_next == STEP_VMAJ) begin
            if (!is_dig) err = ERR_VERSION;
            else begin
              vdig_next = 8'(d) * 8'd10; step_next = STEP_VDOT;
            end
          end else if (step_next == STEP_VDOT) begin
            if (data_byte != BYTE_DOT) err = ERR_VERSION;
            else step_next = STEP_VMIN;
          end else if (step_next == STEP_VMIN) begin
            if (!is_dig || !(vsum == 8'd10 || vsum == 8'd11 || vsum == 8'd20))
              err = ERR_VERSION;
            else begin
              vdig_next = vsum; step_next = cfg_mode ? STEP_SP1 : STEP_DONE;
            end
          end else if (step_next == STEP_SP1 || step_next == STEP_SP2) begin
            if (data_byte != BYTE_SP) err = ERR_NO_SPACE;
            else step_next = (step_next == STEP_SP1) ? STEP_ST0 : STEP_DONE;
          end else if (step_next >= STEP_ST0 && step_next <= STEP_ST2) begin
            if (!is_dig || (step_next == STEP_ST0 && data_byte == BYTE_ZERO))
              err = ERR_STATUS;
            else begin
              sdig_next = st_mul[9:0]; step_next = step_next + 4'd1;
            end
          end
        end else if (pos == '0 && is_blank) begin
          err = ERR_CONT;
        end else if (!colon_seen && data_byte == BYTE_COLON) begin
          colon_seen_next = 1'b1; colon_pos_next = pos; value_begin_next = pos + LW'(1);
        end else if (colon_seen && pos == value_begin && is_blank) begin
          value_begin_next = pos + LW'(1);
        end
        last_cr_next = data_byte == BYTE_CR;
        if (err != ERR_OK) begin
          sticky_next = err; res.error_code = err;
        end
      end else begin
        if (phase == PH_FIRST) begin
          priority if (step_next == STEP_METHOD) err = ERR_NO_METHOD;
          else if (step_next == STEP_URI) err = ERR_NO_URI;
          else if (step_next <= STEP_PROTO_END) err = ERR_PROTO;
          else if (step_next <= STEP_VMIN) err = ERR_VERSION;
          else if (step_next == STEP_DONE) err = ERR_OK;
          else if (step_next == STEP_SP1 || step_next == STEP_SP2) err = ERR_NO_SPACE;
          else err = ERR_STATUS;
          if (err == ERR_OK) begin
            res.line_done = 1'b1;
            res.version_code = (vdig == 8'd11) ? 2'd1 : (vdig == 8'd20) ? 2'd2 : 2'd0;
            if (cfg_mode) begin
              res.line_kind = KIND_STATUS; res.status_number = sdig;
            end else begin
              res.line_kind = KIND_REQUEST;
              for (int i = 0; i < 4; i++) if (cand[i]) mc = 2'(i);
              res.method_code = mc;
              res.value_start = 10'(uri_begin);
              vlen = (value_begin >= uri_begin) ? value_begin - uri_begin : '0;
              res.value_length = 10'(vlen);
            end
            phase_next = PH_HEADERS;
          end
        end else if (line_length_next == term) begin
          res.line_done = 1'b1; res.line_kind = KIND_END; phase_next = PH_BODY;
        end else if (!colon_seen) begin
          err = ERR_NO_COLON;
        end else begin
          res.line_done = 1'b1; res.line_kind = KIND_HEADER;
          res.name_length = 10'(colon_pos);
          res.value_start = 10'(value_begin);
          vlen = (value_begin + term <= line_length_next) ?
                 line_length_next - term - value_begin : '0;
          res.value_length = 10'(vlen);
        end
        if (err != ERR_OK) begin
          sticky_next = err; res.error_code = err;
        end else nl = 1'b1;
      end
    end
    if (nl) begin
      line_length_next = '0; step_next = STEP_METHOD; cand_next = 4'hf;
      colon_pos_next = '0; colon_seen_next = 1'b0; value_begin_next = '0;
      uri_begin_next = '0; vdig_next = '0; sdig_next = '0; last_cr_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST; line_length <= '0; step <= STEP_METHOD; cand <= 4'hf;
      colon_seen <= 1'b0; colon_pos <= '0; value_begin <= '0; uri_begin <= '0;
      vdig <= '0; sdig <= '0; last_cr <= 1'b0; sticky <= ERR_OK;
    end else if (take) begin
      phase <= phase_next; line_length <= line_length_next; step <= step_next;
      cand <= cand_next; colon_seen <= colon_seen_next; colon_pos <= colon_pos_next;
      value_begin <= value_begin_next; uri_begin <= uri_begin_next;
      vdig <= vdig_next; sdig <= sdig_next; last_cr <= last_cr_next;
      sticky <= sticky_next;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hmp_queue.sv -----
// two-entry result queue between front and back
// uses hmp_pkg
`default_nettype none
module hmp_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire hmp_pkg::result_t wdata,
  output logic full,
  input  wire logic pop,
  output logic empty,
  output hmp_pkg::result_t rdata
);
  import hmp_pkg::*;
  result_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hmp_back.sv -----
// back part: output register that presents result items
// uses hmp_pkg
`default_nettype none
module hmp_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire hmp_pkg::result_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  wire logic out_stall,
  output hmp_pkg::result_t out_res
);
  import hmp_pkg::*;
  logic load;
  assign load = !q_empty && (!out_valid || !out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= q_data;
  end
endmodule
`default_nettype wire

// ----- hdl/http_message_head_parser.sv -----
// top level of the http message head parser
// uses hmp_pkg, hmp_front, hmp_queue, hmp_back
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   data_byte
// out      output     out_valid / out_stall out_byte .. value_length
// cfg      input      cfg_we                cfg_index, cfg_data
//
// one item per cycle while in_stall is low
// front parse registers update in the cycle of accept; a two-entry queue
// feeds the output register, so in_stall rises only when the queue is full
// rst is synchronous and clears parse state, queue and registers
`default_nettype none
module http_message_head_parser (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] data_byte,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_byte,
  output logic [9:0] line_offset,
  output logic in_body,
  output logic line_done,
  output logic [2:0] line_kind,
  output logic [3:0] error_code,
  output logic [1:0] method_code,
  output logic [1:0] version_code,
  output logic [9:0] status_number,
  output logic [9:0] name_length,
  output logic [9:0] value_start,
  output logic [9:0] value_length,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [10:0] cfg_data
);
  import hmp_pkg::*;
  localparam logic REG_MODE = 1'b0;

  logic parse_mode;
  logic [10:0] max_line_length;
  logic take, full, empty, pop;
  result_t fres, qres, ores;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= 1'b0; max_line_length <= 11'd1024;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) parse_mode <= cfg_data[0];
      else max_line_length <= cfg_data;
    end
  end

  assign in_stall = full;
  assign take = in_valid && !full;

  hmp_front u_front (.clk, .rst, .cfg_mode(parse_mode), .cfg_max(max_line_length),
                     .take, .data_byte, .res(fres));
  hmp_queue u_queue (.clk, .rst, .push(take), .wdata(fres), .full, .pop, .empty,
                     .rdata(qres));
  hmp_back u_back (.clk, .rst, .q_empty(empty), .q_data(qres), .q_pop(pop),
                   .out_valid, .out_stall, .out_res(ores));

  assign out_byte = ores.out_byte;
  assign line_offset = ores.line_offset;
  assign in_body = ores.in_body;
  assign line_done = ores.line_done;
  assign line_kind = ores.line_kind;
  assign error_code = ores.error_code;
  assign method_code = ores.method_code;
  assign version_code = ores.version_code;
  assign status_number = ores.status_number;
  assign name_length = ores.name_length;
  assign value_start = ores.value_start;
  assign value_length = ores.value_length;
endmodule
`default_nettype wire

// ----- hdl/hmp_checker.sv -----
// port-level checker for the http message head parser, with its bind
// uses http_message_head_parser_macros.svh and hmp_pkg
`default_nettype none
`include "http_message_head_parser_macros.svh"
module hmp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [7:0] out_byte,
  input wire logic in_body,
  input wire logic line_done,
  input wire logic [2:0] line_kind,
  input wire logic [3:0] error_code
);
  import hmp_pkg::*;
  `HMP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_byte))
  `HMP_ASSERT_IMPL(a_done_ok, out_valid && line_done, error_code == ERR_OK && line_kind != KIND_NONE)
  `HMP_ASSERT_IMPL(a_body_ok, out_valid && in_body, error_code == ERR_OK && !line_done)
  `HMP_ASSERT_IMPL(a_kind, out_valid && !line_done, line_kind == KIND_NONE)
endmodule
bind http_message_head_parser hmp_checker u_hmp_checker (.clk, .rst, .out_valid,
  .out_stall, .out_byte, .in_body, .line_done, .line_kind, .error_code);
`default_nettype wire

// ----- tb/sv/tb_http_message_head_parser.sv -----
// self-checking testbench for http_message_head_parser
// depends on hmp_pkg and the parser rtl; predicts every result item in sv
`timescale 1ns / 1ps
`default_nettype none
module tb_http_message_head_parser;
  import hmp_pkg::*;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    string text;
    bit chk;
    logic [2:0] kind;
    logic [3:0] err;
  } line_row_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [7:0] data_byte;
  logic out_valid, out_stall;
  logic [7:0] out_byte;
  logic [9:0] line_offset;
  logic in_body, line_done;
  logic [2:0] line_kind;
  logic [3:0] error_code;
  logic [1:0] method_code, version_code;
  logic [9:0] status_number, name_length, value_start, value_length;
  logic cfg_we, cfg_index;
  logic [10:0] cfg_data;

  http_message_head_parser dut (.*);

  // predictor state
  logic cfg_mode;
  int cfg_max;
  logic [1:0] ph;
  int llen, step, cpos, vbeg, ubeg, vdig, sdig;
  logic [3:0] cand;
  bit cseen, last_cr;
  logic [3:0] sticky;
  string mtext[4] = '{"GET", "POST", "PUT", "DELETE"};
  string proto = "HTTP/";

  result_t expected_q[$];
  int mismatches = 0;
  bit idle_en = 1;
  bit hold_req = 0;
  int stall_left = 0;
  int quiet = 0;

  line_row_t directed[3] = '{
    '{"PUT / HTTP/1.0\n", 1, KIND_REQUEST, ERR_OK},
    '{"A:\t\377\r\n", 1, KIND_HEADER, ERR_OK},
    '{"B:\n", 1, KIND_HEADER, ERR_OK}
  };

  function automatic void new_line();
    llen = 0; step = STEP_METHOD; cand = 4'hF; cpos = 0; cseen = 0;
    vbeg = 0; ubeg = 0; vdig = 0; sdig = 0; last_cr = 0;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == BYTE_SP || b == BYTE_TAB;
  endfunction

  function automatic logic [3:0] scan_first_line(logic [7:0] b, int pos);
    int hit;
    int v;
    if (step == STEP_METHOD) begin
      if (b == BYTE_SP) begin
        hit = 0;
        for (int i = 0; i < 4; i++)
          if (cand[i] && mtext[i].len() == pos) hit = 1 << i;
        if (hit == 0) return ERR_BAD_METHOD;
        cand = 4'(hit);
        ubeg = pos + 1;
        step = STEP_URI;
      end else begin
        for (int i = 0; i < 4; i++)
          if (!(pos < mtext[i].len() && mtext[i][pos] == b)) cand[i] = 1'b0;
      end
    end else if (step == STEP_URI) begin
      if (b == BYTE_SP) begin
        vbeg = pos;
        step = STEP_PROTO;
      end
    end else if (step >= STEP_PROTO && step <= STEP_PROTO_END) begin
      if (b != proto[step - STEP_PROTO]) return ERR_PROTO;
      step++;
    end else if (step == STEP_VMAJ) begin
      if (!is_digit(b)) return ERR_VERSION;
      vdig = (b - 48) * 10;
      step = STEP_VDOT;
    end else if (step == STEP_VDOT) begin
      if (b != BYTE_DOT) return ERR_VERSION;
      step = STEP_VMIN;
    end else if (step == STEP_VMIN) begin
      if (!is_digit(b)) return ERR_VERSION;
      v = vdig + (b - 48);
      if (v != 10 && v != 11 && v != 20) return ERR_VERSION;
      vdig = v;
      step = cfg_mode ? STEP_SP1 : STEP_DONE;
    end else if (step == STEP_SP1 || step == STEP_SP2) begin
      if (b != BYTE_SP) return ERR_NO_SPACE;
      step = (step == STEP_SP1) ? STEP_ST0 : STEP_DONE;
    end else if (step >= STEP_ST0 && step <= STEP_ST2) begin
      if (!is_digit(b) || (step == STEP_ST0 && b == BYTE_ZERO)) return ERR_STATUS;
      sdig = (sdig * 10 + (b - 48)) & 1023;
      step++;
    end
    return ERR_OK;
  endfunction

  function automatic logic [3:0] first_line_end_err();
    if (step == STEP_METHOD) return ERR_NO_METHOD;
    if (step == STEP_URI) return ERR_NO_URI;
    if (step <= STEP_PROTO_END) return ERR_PROTO;
    if (step <= STEP_VMIN) return ERR_VERSION;
    if (step == STEP_DONE) return ERR_OK;
    if (step == STEP_SP1 || step == STEP_SP2) return ERR_NO_SPACE;
    return ERR_STATUS;
  endfunction

  function automatic result_t parse_byte(logic [7:0] b);
    result_t r;
    int limit, pos, term;
    logic [3:0] err;
    r = '0;
    r.out_byte = b;
    err = ERR_OK;
    if (sticky != ERR_OK) begin
      r.error_code = sticky;
      return r;
    end
    if (ph == PH_BODY) begin
      r.in_body = 1'b1;
      return r;
    end
    limit = (cfg_max < MAX_LINE) ? cfg_max : MAX_LINE;
    if (llen >= limit) begin
      sticky = ERR_LONG;
      r.line_offset = 10'(llen);
      r.error_code = ERR_LONG;
      return r;
    end
    pos = llen;
    llen++;
    r.line_offset = 10'(pos);
    if (ph == PH_FIRST && pos == 0 && step == STEP_METHOD && cfg_mode) step = STEP_PROTO;
    if (b != BYTE_LF) begin
      if (ph == PH_FIRST) err = scan_first_line(b, pos);
      else if (pos == 0 && is_blank(b)) err = ERR_CONT;
      else if (!cseen && b == BYTE_COLON) begin
        cseen = 1; cpos = pos; vbeg = pos + 1;
      end else if (cseen && pos == vbeg && is_blank(b)) vbeg = pos + 1;
      last_cr = (b == BYTE_CR);
      if (err != ERR_OK) begin
        sticky = err;
        r.error_code = err;
      end
      return r;
    end
    term = last_cr ? 2 : 1;
    if (ph == PH_FIRST) begin
      err = first_line_end_err();
      if (err == ERR_OK) begin
        r.line_done = 1'b1;
        r.version_code = (vdig == 11) ? 2'd1 : (vdig == 20) ? 2'd2 : 2'd0;
        if (cfg_mode) begin
          r.line_kind = KIND_STATUS;
          r.status_number = 10'(sdig);
        end else begin
          r.line_kind = KIND_REQUEST;
          for (int i = 0; i < 4; i++) if (cand[i]) r.method_code = 2'(i);
          r.value_start = 10'(ubeg);
          r.value_length = 10'(vbeg >= ubeg ? vbeg - ubeg : 0);
        end
        ph = PH_HEADERS;
      end
    end else if (llen == term) begin
      r.line_done = 1'b1;
      r.line_kind = KIND_END;
      ph = PH_BODY;
    end else if (!cseen) begin
      err = ERR_NO_COLON;
    end else begin
      r.line_done = 1'b1;
      r.line_kind = KIND_HEADER;
      r.name_length = 10'(cpos);
      r.value_start = 10'(vbeg);
      r.value_length = 10'(vbeg + term <= llen ? llen - term - vbeg : 0);
    end
    if (err != ERR_OK) begin
      sticky = err;
      r.error_code = err;
      return r;
    end
    new_line();
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender side
  task automatic send_byte(logic [7:0] b, bit chk = 0, logic [2:0] kind = KIND_NONE,
                           logic [3:0] err = ERR_OK);
    result_t r;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    r = parse_byte(b);
    if (chk) begin
      r.line_kind = kind;
      r.error_code = err;
    end
    expected_q.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) cfg_mode = val[0];
    else cfg_max = val & 11'h7FF;
  endtask

  function automatic logic [7:0] rand_value_byte();
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) return ($urandom_range(0, 1) ? BYTE_SP : BYTE_TAB);
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF);
    return b;
  endfunction

  task automatic send_header(int lim, inout int sent);
    int total, term, body, c;
    logic [7:0] b;
    total = ($urandom_range(0, 15) == 0) ? $urandom_range(3, lim) : $urandom_range(3, 24);
    if (total > lim) total = lim;
    term = (total > 2 && $urandom_range(0, 1)) ? 2 : 1;
    body = total - term;
    c = $urandom_range(0, body - 1);
    for (int i = 0; i < body; i++) begin
      if (i == c) b = BYTE_COLON;
      else if (i < c) begin
        do b = 8'($urandom_range(0, 255));
        while (b == BYTE_LF || b == BYTE_COLON || (i == 0 && is_blank(b)));
      end else b = rand_value_byte();
      send_byte(b);
    end
    if (term == 2) send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    sent += total;
  endtask

  initial begin
    int sent;
    logic [7:0] b;
    bit held;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_data <= '0;
    cfg_mode = 1'b0;
    cfg_max = 1024;
    ph = PH_FIRST;
    sticky = ERR_OK;
    held = 0;
    new_line();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_MODE, 0);
    write_reg(CFG_MAXLEN, 2047);

    foreach (directed[r]) begin
      for (int i = 0; i < directed[r].text.len(); i++) begin
        if (i == directed[r].text.len() - 1)
          send_byte(directed[r].text[i], directed[r].chk, directed[r].kind, directed[r].err);
        else
          send_byte(directed[r].text[i]);
      end
    end

    sent = 0;
    while (sent < 500) begin
      if (!held && sent > 200) begin
        hold_req = 1;
        held = 1;
      end
      send_header(1024, sent);
    end
    drain();

    write_reg(CFG_MAXLEN, 16);
    sent = 0;
    while (sent < 500) send_header(16, sent);
    drain();

    write_reg(CFG_MODE, 1);
    write_reg(CFG_MAXLEN, 1024);
    idle_en = 0;
    sent = 0;
    while (sent < 500) send_header(1024, sent);

    case ($urandom_range(0, 2))
      0: begin
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        drain();
        write_reg(CFG_MAXLEN, 1);
        repeat (40) send_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        drain();
        write_reg(CFG_MAXLEN, 1);
        repeat (40) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat (5) begin
          do b = 8'($urandom_range(0, 255));
          while (b == BYTE_LF || b == BYTE_COLON || is_blank(b));
          send_byte(b);
        end
        send_byte(BYTE_LF);
        repeat (20) send_byte(8'($urandom_range(0, 255)));
        drain();
        write_reg(CFG_MAXLEN, 1);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // receiver side
  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t %s expected %0d actual %0d", $realtime, name, e, a);
      mismatches++;
    end
  endtask

  initial begin
    result_t e;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected item expected none actual byte %0d", $realtime, out_byte);
          mismatches++;
        end else begin
          e = expected_q.pop_front();
          check_field("out_byte", e.out_byte, out_byte);
          check_field("line_offset", e.line_offset, line_offset);
          check_field("in_body", e.in_body, in_body);
          check_field("line_done", e.line_done, line_done);
          check_field("line_kind", e.line_kind, line_kind);
          check_field("error_code", e.error_code, error_code);
          check_field("method_code", e.method_code, method_code);
          check_field("version_code", e.version_code, version_code);
          check_field("status_number", e.status_number, status_number);
          check_field("name_length", e.name_length, name_length);
          check_field("value_start", e.value_start, value_start);
          check_field("value_length", e.value_length, value_length);
        end
      end
      if (hold_req) begin
        hold_req = 0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire
